// ===== hdl/fpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared types, constants and the prbs update for the matrix row generator.
// ----------------------------------------------------------------------------
package fpm_pkg;

    localparam int NUM_COLUMNS_W   = 11;
    localparam int NUM_COLUMNS_RST = 16;
    localparam int LINE_W          = 16;

    localparam int PRBS_W      = 27;
    localparam int PRBS_TAP    = 5;
    localparam int PRBS_FB_BIT = 22;
    localparam int SEED_MULT   = 1001;

    // remainder unit: digits retired per cycle
    localparam int DIV_DIGITS = 4;
    localparam int DIV_CYCLES = (PRBS_W + DIV_DIGITS - 1) / DIV_DIGITS;
    localparam int DIV_PAD_W  = DIV_CYCLES * DIV_DIGITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int REM_W      = NUM_COLUMNS_W;

    localparam int REJECT_LIMIT = 4096;
    localparam int TRY_W        = $clog2(REJECT_LIMIT);
    localparam int PICK_W       = NUM_COLUMNS_W - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    // running column base during word output, holds count + word width
    localparam int BASE_W = NUM_COLUMNS_W + 1;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_IDENT,
        FR_STEP,
        FR_DIV,
        FR_PUSH,
        FR_END
    } fr_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_QUOT,
        BK_ADDR,
        BK_READ,
        BK_WRITE,
        BK_EMIT_RD,
        BK_EMIT_LD
    } bk_state_t;

    function automatic logic [PRBS_W-1:0] prbs_step(input logic [PRBS_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[PRBS_TAP];
        return (v >> 1) + (PRBS_W'(fb) << PRBS_FB_BIT);
    endfunction

endpackage

// ===== hdl/fpm_pick_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_pick_front
// Accepts a line index, classifies the row and pushes column set commands
// followed by an end-of-row command into the queue.
// ----------------------------------------------------------------------------
module fpm_pick_front #(
    parameter int COL_W = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [fpm_pkg::NUM_COLUMNS_W-1:0] m_eff,
    input  logic                             clearing,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fpm_pkg::LINE_W-1:0]       line_index,
    output logic                             push_valid,
    input  logic                             push_ready,
    output logic                             push_end,
    output logic [COL_W-1:0]                 push_col
);

    fpm_pkg::fr_state_t state_reg, state_next;

    logic [fpm_pkg::PRBS_W-1:0]        prbs_reg, prbs_next;
    logic [fpm_pkg::NUM_COLUMNS_W-1:0] m_reg, m_next;
    logic [fpm_pkg::NUM_COLUMNS_W-1:0] modv_reg, modv_next;
    logic [fpm_pkg::PICK_W-1:0]        picks_reg, picks_next;
    logic [fpm_pkg::TRY_W-1:0]         tries_reg, tries_next;
    logic [fpm_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [fpm_pkg::DIV_PAD_W-1:0]     div_shift_reg, div_shift_next;
    logic [fpm_pkg::DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic [COL_W-1:0]                  col_reg, col_next;

    logic [fpm_pkg::REM_W-1:0]  div_rem;
    logic [fpm_pkg::PRBS_W-1:0] seed;
    logic [fpm_pkg::PRBS_W-1:0] stepped;
    logic                       m_pow2;
    logic                       pick_done;

    // seed = 1 + 1001 * (n + 1)
    assign seed = fpm_pkg::PRBS_W'(line_index) * fpm_pkg::PRBS_W'(fpm_pkg::SEED_MULT)
                + fpm_pkg::PRBS_W'(fpm_pkg::SEED_MULT + 1);
    assign stepped = fpm_pkg::prbs_step(prbs_reg);
    assign m_pow2  = ((m_eff & (m_eff - fpm_pkg::NUM_COLUMNS_W'(1))) == '0);

    // restoring remainder, several dividend bits per cycle
    always_comb
    begin
        logic [fpm_pkg::REM_W:0]   t;
        logic [fpm_pkg::REM_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < fpm_pkg::DIV_DIGITS; i++)
        begin
            t = {r, div_shift_reg[fpm_pkg::DIV_PAD_W-1-i]};
            if (t >= {1'b0, modv_reg})
            begin
                t = t - {1'b0, modv_reg};
            end
            r = t[fpm_pkg::REM_W-1:0];
        end
        div_rem = r;
    end

    assign in_ready = (state_reg == fpm_pkg::FR_IDLE) && !clearing;

    always_comb
    begin
        state_next     = state_reg;
        prbs_next      = prbs_reg;
        m_next         = m_reg;
        modv_next      = modv_reg;
        picks_next     = picks_reg;
        tries_next     = tries_reg;
        rem_next       = rem_reg;
        div_shift_next = div_shift_reg;
        div_cnt_next   = div_cnt_reg;
        col_next       = col_reg;
        push_valid     = 1'b0;
        push_end       = 1'b0;
        push_col       = col_reg;
        pick_done      = 1'b0;

        case (state_reg)
            fpm_pkg::FR_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    m_next = m_eff;
                    if (line_index < fpm_pkg::LINE_W'(m_eff))
                    begin
                        col_next   = COL_W'(line_index);
                        state_next = fpm_pkg::FR_IDENT;
                    end
                    else if (m_eff >= fpm_pkg::NUM_COLUMNS_W'(2))
                    begin
                        prbs_next  = seed;
                        modv_next  = m_eff + fpm_pkg::NUM_COLUMNS_W'(m_pow2);
                        picks_next = m_eff[fpm_pkg::NUM_COLUMNS_W-1:1];
                        tries_next = '0;
                        state_next = fpm_pkg::FR_STEP;
                    end
                    else
                    begin
                        state_next = fpm_pkg::FR_END;
                    end
                end
            end
            fpm_pkg::FR_IDENT:
            begin
                push_valid = 1'b1;
                if (push_ready)
                begin
                    state_next = fpm_pkg::FR_END;
                end
            end
            fpm_pkg::FR_STEP:
            begin
                prbs_next      = stepped;
                div_shift_next = fpm_pkg::DIV_PAD_W'(stepped);
                rem_next       = '0;
                div_cnt_next   = '0;
                state_next     = fpm_pkg::FR_DIV;
            end
            fpm_pkg::FR_DIV:
            begin
                rem_next       = div_rem;
                div_shift_next = div_shift_reg << fpm_pkg::DIV_DIGITS;
                div_cnt_next   = div_cnt_reg + fpm_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == fpm_pkg::DIV_CNT_W'(fpm_pkg::DIV_CYCLES - 1))
                begin
                    state_next = fpm_pkg::FR_PUSH;
                end
            end
            fpm_pkg::FR_PUSH:
            begin
                if (rem_reg < m_reg)
                begin
                    push_valid = 1'b1;
                    push_col   = COL_W'(rem_reg);
                    if (push_ready)
                    begin
                        pick_done = 1'b1;
                    end
                end
                else if (tries_reg == fpm_pkg::TRY_W'(fpm_pkg::REJECT_LIMIT - 1))
                begin
                    // too many rejected draws, drop this pick
                    pick_done = 1'b1;
                end
                else
                begin
                    tries_next = tries_reg + fpm_pkg::TRY_W'(1);
                    state_next = fpm_pkg::FR_STEP;
                end

                if (pick_done)
                begin
                    tries_next = '0;
                    if (picks_reg == fpm_pkg::PICK_W'(1))
                    begin
                        state_next = fpm_pkg::FR_END;
                    end
                    else
                    begin
                        picks_next = picks_reg - fpm_pkg::PICK_W'(1);
                        state_next = fpm_pkg::FR_STEP;
                    end
                end
            end
            fpm_pkg::FR_END:
            begin
                push_valid = 1'b1;
                push_end   = 1'b1;
                if (push_ready)
                begin
                    state_next = fpm_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = fpm_pkg::FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpm_pkg::FR_IDLE;
            prbs_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            prbs_reg  <= prbs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg         <= m_next;
        modv_reg      <= modv_next;
        picks_reg     <= picks_next;
        tries_reg     <= tries_next;
        rem_reg       <= rem_next;
        div_shift_reg <= div_shift_next;
        div_cnt_reg   <= div_cnt_next;
        col_reg       <= col_next;
    end

    a_rem_below_modulus: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpm_pkg::FR_PUSH |-> rem_reg < modv_reg)
        else $error("remainder not below modulus");

    a_picks_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpm_pkg::FR_STEP || state_reg == fpm_pkg::FR_DIV
         || state_reg == fpm_pkg::FR_PUSH) |-> picks_reg != '0)
        else $error("drawing with no pick left");

endmodule

// ===== hdl/fpm_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_cmd_queue
// Small first-in first-out queue of row commands between front and back.
// ----------------------------------------------------------------------------
module fpm_cmd_queue #(
    parameter int WIDTH = 11
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [fpm_pkg::QUEUE_DEPTH];

    logic [fpm_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [fpm_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [fpm_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != fpm_pkg::QUEUE_CNT_W'(fpm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + fpm_pkg::QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + fpm_pkg::QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + fpm_pkg::QUEUE_CNT_W'(do_push)
                    - fpm_pkg::QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fpm_pkg::QUEUE_CNT_W'(fpm_pkg::QUEUE_DEPTH)
        && fpm_pkg::QUEUE_PTR_W'(wr_ptr_reg - rd_ptr_reg)
           == fpm_pkg::QUEUE_PTR_W'(count_reg))
        else $error("queue count out of step with pointers");

endmodule

// ===== hdl/fpm_row_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpm_row_back
// Holds the row in a word memory, sets picked columns by read-modify-write
// and streams the row out word by word, zeroing each word as it is read.
// ----------------------------------------------------------------------------
module fpm_row_back #(
    parameter int MAX_COLUMNS = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [fpm_pkg::NUM_COLUMNS_W-1:0] m_eff,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic                              cmd_end,
    input  logic [$clog2(MAX_COLUMNS)-1:0]    cmd_col,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [WORD_BITS-1:0]              row_word,
    output logic                              last_word
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int DEPTH  = (MAX_COLUMNS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int SHIFT  = COL_W + 7;
    localparam int RECIP  = (1 << SHIFT) / WORD_BITS;
    localparam int PROD_W = COL_W + SHIFT;
    localparam int DIFF_W = COL_W + 8;
    localparam int RW     = $clog2(2 * WORD_BITS);

    logic [WORD_BITS-1:0] row_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    fpm_pkg::bk_state_t state_reg, state_next;

    logic [AW-1:0]              clr_reg, clr_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [COL_W-1:0]           q_reg, q_next;
    logic [AW-1:0]              addr_reg, addr_next;
    logic [BW-1:0]              bit_reg, bit_next;
    logic [AW-1:0]              w_reg, w_next;
    logic [fpm_pkg::BASE_W-1:0] base_reg, base_next;
    logic                       out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0]       word_reg, word_next;
    logic                       last_reg, last_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [PROD_W-1:0]    prod;
    logic [DIFF_W-1:0]    diff;
    logic [RW-1:0]        rsub;
    logic                 is_last;

    assign clearing  = (state_reg == fpm_pkg::BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign row_word  = word_reg;
    assign last_word = last_reg;

    // column / word width by reciprocal, estimate is low by at most one
    assign prod = PROD_W'(col_reg) * PROD_W'(RECIP);
    assign diff = DIFF_W'(col_reg) - DIFF_W'(q_reg) * DIFF_W'(WORD_BITS);
    assign rsub = RW'(diff);
    assign is_last = (base_reg + fpm_pkg::BASE_W'(WORD_BITS)) >= fpm_pkg::BASE_W'(m_eff);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        col_next       = col_reg;
        q_next         = q_reg;
        addr_next      = addr_reg;
        bit_next       = bit_reg;
        w_next         = w_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg && !out_ready;
        word_next      = word_reg;
        last_next      = last_reg;
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;

        case (state_reg)
            fpm_pkg::BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = fpm_pkg::BK_IDLE;
                end
            end
            fpm_pkg::BK_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (cmd_end)
                    begin
                        w_next     = '0;
                        base_next  = '0;
                        state_next = fpm_pkg::BK_EMIT_RD;
                    end
                    else
                    begin
                        col_next   = cmd_col;
                        state_next = fpm_pkg::BK_QUOT;
                    end
                end
            end
            fpm_pkg::BK_QUOT:
            begin
                q_next     = COL_W'(prod >> SHIFT);
                state_next = fpm_pkg::BK_ADDR;
            end
            fpm_pkg::BK_ADDR:
            begin
                if (rsub >= RW'(WORD_BITS))
                begin
                    addr_next = AW'(q_reg) + AW'(1);
                    bit_next  = BW'(rsub - RW'(WORD_BITS));
                end
                else
                begin
                    addr_next = AW'(q_reg);
                    bit_next  = BW'(rsub);
                end
                state_next = fpm_pkg::BK_READ;
            end
            fpm_pkg::BK_READ:
            begin
                mem_re     = 1'b1;
                mem_raddr  = addr_reg;
                state_next = fpm_pkg::BK_WRITE;
            end
            fpm_pkg::BK_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = addr_reg;
                mem_wdata  = rd_data_reg
                           | (WORD_BITS'(1) << (BW'(WORD_BITS - 1) - bit_reg));
                state_next = fpm_pkg::BK_IDLE;
            end
            fpm_pkg::BK_EMIT_RD:
            begin
                // read the word and zero it for the next row
                mem_re     = 1'b1;
                mem_raddr  = w_reg;
                mem_we     = 1'b1;
                mem_waddr  = w_reg;
                state_next = fpm_pkg::BK_EMIT_LD;
            end
            fpm_pkg::BK_EMIT_LD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    word_next      = rd_data_reg;
                    last_next      = is_last;
                    if (is_last)
                    begin
                        state_next = fpm_pkg::BK_IDLE;
                    end
                    else
                    begin
                        w_next     = w_reg + AW'(1);
                        base_next  = base_reg + fpm_pkg::BASE_W'(WORD_BITS);
                        state_next = fpm_pkg::BK_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = fpm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpm_pkg::BK_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg  <= col_next;
        q_reg    <= q_next;
        addr_reg <= addr_next;
        bit_reg  <= bit_next;
        w_reg    <= w_next;
        base_reg <= base_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= row_mem[mem_raddr];
        end
    end

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> mem_waddr <= AW'(DEPTH - 1))
        else $error("row memory write beyond depth");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fpm_pkg::BK_EMIT_RD |-> w_reg <= AW'(DEPTH - 1))
        else $error("row output past last word");

endmodule

// ===== hdl/fec_parity_matrix_row_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fec_parity_matrix_row_gen
// Steps: an identity row pushes its one column; a coded row makes a prbs draw
// per pick (step, remainder unit at 4 bits a cycle, check) for num_columns/2
// picks plus rejected draws; each output word is then read and loaded.
// Throughput: one row at a time in the front; its draw loop sets the rate.
// Reset: num_columns = 16; the row memory is swept to zero, one word a cycle
// (32 words at default size), with in_ready low during the sweep.
// ----------------------------------------------------------------------------
module fec_parity_matrix_row_gen #(
    parameter int MAX_COLUMNS = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpm_pkg::NUM_COLUMNS_W-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [fpm_pkg::LINE_W-1:0]        line_index,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [WORD_BITS-1:0]              row_word,
    output logic                              last_word
);

    localparam int COL_W = $clog2(MAX_COLUMNS);

    logic [fpm_pkg::NUM_COLUMNS_W-1:0] num_columns_reg, num_columns_next;
    logic [fpm_pkg::NUM_COLUMNS_W-1:0] m_eff;

    logic             push_valid;
    logic             push_ready;
    logic             push_end;
    logic [COL_W-1:0] push_col;
    logic             pop_valid;
    logic             pop_ready;
    logic [COL_W:0]   pop_data;
    logic             clearing;

    assign cfg_ready        = 1'b1;
    assign num_columns_next = (cfg_valid && cfg_ready) ? cfg_data : num_columns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_columns_reg <= fpm_pkg::NUM_COLUMNS_W'(fpm_pkg::NUM_COLUMNS_RST);
        end
        else
        begin
            num_columns_reg <= num_columns_next;
        end
    end

    // column count limited to the row memory size
    assign m_eff = (32'(num_columns_reg) > 32'(MAX_COLUMNS))
                 ? fpm_pkg::NUM_COLUMNS_W'(MAX_COLUMNS) : num_columns_reg;

    fpm_pick_front #(
        .COL_W (COL_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .m_eff      (m_eff),
        .clearing   (clearing),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .line_index (line_index),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_end   (push_end),
        .push_col   (push_col)
    );

    fpm_cmd_queue #(
        .WIDTH (COL_W + 1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_end, push_col}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    fpm_row_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .WORD_BITS   (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .m_eff     (m_eff),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_end   (pop_data[COL_W]),
        .cmd_col   (pop_data[COL_W-1:0]),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row_word  (row_word),
        .last_word (last_word)
    );

endmodule
